FILE: rtl/esc_pkg.sv
// esc_pkg: shared types, constants and tables for the epoch seconds to calendar block
// used by esc_div and epoch_seconds_to_calendar_top; depends on nothing else
`default_nettype none

package esc_pkg;

    // shared divider sizes
    localparam int DIV_W = 64;
    localparam int REM_W = 18;
    localparam int CNT_W = 6;

    // divisors and calendar constants
    localparam logic [REM_W-1:0] SECS_PER_DAY  = 18'd86400;
    localparam logic [REM_W-1:0] SECS_PER_HOUR = 18'd3600;
    localparam logic [REM_W-1:0] SECS_PER_MIN  = 18'd60;
    localparam logic [REM_W-1:0] DAYS_PER_ERA  = 18'd146097;
    localparam logic [REM_W-1:0] DAYS_PER_4Y   = 18'd1460;
    localparam logic [REM_W-1:0] DAYS_PER_YEAR = 18'd365;
    localparam logic [REM_W-1:0] MONTH_DIV     = 18'd153;
    localparam logic [63:0]      SERIAL_HALF   = 64'h0000_0000_7fff_ffff;
    localparam logic [63:0]      DAYS_TO_LIMIT = 64'd2932897;
    localparam logic [21:0]      EPOCH_SHIFT   = 22'd719468;
    localparam logic [13:0]      YEARS_PER_ERA = 14'd400;

    // radix-4 passes for each division (two quotient bits a pass)
    localparam logic [CNT_W-1:0] STEPS_DAYS  = 6'd32;
    localparam logic [CNT_W-1:0] STEPS_ERA   = 6'd11;
    localparam logic [CNT_W-1:0] STEPS_18B   = 6'd9;
    localparam logic [CNT_W-1:0] STEPS_12B   = 6'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIDEN,
        ST_DAYS,
        ST_ERA,
        ST_CENT,
        ST_YOE,
        ST_DOY,
        ST_MONTH,
        ST_HOUR,
        ST_MIN,
        ST_OUT
    } esc_state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [REM_W-1:0] divisor;
        logic [CNT_W-1:0] steps;
    } esc_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [REM_W-1:0] remainder;
    } esc_div_rsp_t;

    // first day of each month in a march-based year
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] off;
        case (mp)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/esc_div.sv
// esc_div: shared radix-4 restoring divider, two quotient bits per cycle
// depends on esc_pkg; the dividend arrives left-aligned, the quotient ends in the low bits
`default_nettype none

module esc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  esc_pkg::esc_div_req_t req,
    output esc_pkg::esc_div_rsp_t rsp
);
    import esc_pkg::*;

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [REM_W:0]   part1, part2, diff1, diff2;
    logic [REM_W-1:0] r1, r2;
    logic             b1, b2;

    // two compare-subtract steps
    always_comb
    begin
        part1 = {rem_reg, quo_reg[DIV_W-1]};
        diff1 = part1 - {1'b0, dvs_reg};
        b1    = (part1 >= {1'b0, dvs_reg});
        r1    = b1 ? diff1[REM_W-1:0] : part1[REM_W-1:0];
        part2 = {r1, quo_reg[DIV_W-2]};
        diff2 = part2 - {1'b0, dvs_reg};
        b2    = (part2 >= {1'b0, dvs_reg});
        r2    = b2 ? diff2[REM_W-1:0] : part2[REM_W-1:0];
    end

    // load, iterate, flag completion
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
            cnt_next = req.steps;
        end
        else if (cnt_reg != '0)
        begin
            quo_next  = {quo_reg[DIV_W-3:0], b1, b2};
            rem_next  = r2;
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/epoch_seconds_to_calendar_top.sv
// epoch_seconds_to_calendar_top: seconds since 1970 to UTC date and time of day
// depends on esc_pkg and esc_div
//
// usage
// - input channel: in_valid / in_stall with func, seconds_in, now_seconds. func 0 takes
//   the full 64-bit count; func 1 takes the low 32 bits as a serial time and widens it
//   to the first value not earlier than now_seconds - 0x7fffffff
// - output channel: out_valid / out_stall with year, month, day, hour, minute, second
//   and out_of_range; a year past 9999 sets out_of_range and zeroes the other fields
// - one request at a time: in_stall is high from acceptance until the result is taken
// - the shared radix-4 divider runs the divisions one after another: 32 passes for the
//   day split, then 11, 9, 9, 6, 9 and 6 passes for a date in range; an out-of-range
//   date goes to the output straight after the day split
// - a stalled result holds in the output registers until out_stall drops
// - reset (rst_n low, asynchronous) returns the sequencer to idle and drops out_valid
`default_nettype none

module epoch_seconds_to_calendar_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [63:0] seconds_in,
    input  logic [62:0] now_seconds,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [13:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic        out_of_range
);
    import esc_pkg::*;

    esc_state_t   state_reg, state_next;
    esc_div_req_t div_req;
    esc_div_rsp_t div_rsp;

    logic        func_reg, func_next;
    logic [63:0] secs_reg, secs_next;
    logic [63:0] start_reg, start_next;
    logic [16:0] sec_day_reg, sec_day_next;
    logic [4:0]  era_reg, era_next;
    logic [17:0] doe_reg, doe_next;
    logic [8:0]  yoe_reg, yoe_next;
    logic [8:0]  doy_reg, doy_next;
    logic [13:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic        oor_reg, oor_next;

    // serial widening
    logic        start_pos;
    logic [31:0] hi_inc;
    logic [63:0] widened, day_dividend;

    // day count checks
    logic        days_oor;
    logic [21:0] z_val;

    // year-of-era numerator
    logic [2:0]  c36524;
    logic        last_day;
    logic [17:0] yoe_num;

    // day of year
    logic [1:0]  yc100;
    logic [17:0] yoe_base, doy_full;
    logic [11:0] mp_num;

    // month, day and year
    logic [3:0]  mp_val;
    logic [8:0]  day_full;
    logic [3:0]  month_val;

    esc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // widen a serial time around the current time
    always_comb
    begin
        start_pos    = !start_reg[63] && (start_reg != '0);
        hi_inc       = start_reg[63:32] + 32'd1;
        if (!start_pos)
            widened = {32'b0, secs_reg[31:0]};
        else if (secs_reg[31:0] >= start_reg[31:0])
            widened = {start_reg[63:32], secs_reg[31:0]};
        else
            widened = {hi_inc, secs_reg[31:0]};
        day_dividend = func_reg ? widened : secs_reg;
    end

    // per-stage arithmetic on divider results
    always_comb
    begin
        days_oor  = (div_rsp.quotient >= DAYS_TO_LIMIT);
        z_val     = div_rsp.quotient[21:0] + EPOCH_SHIFT;

        c36524    = {2'b0, doe_reg >= 18'd36524} + {2'b0, doe_reg >= 18'd73048}
                  + {2'b0, doe_reg >= 18'd109572} + {2'b0, doe_reg >= 18'd146096};
        last_day  = (doe_reg == 18'd146096);
        yoe_num   = doe_reg - {11'b0, div_rsp.quotient[6:0]} + {15'b0, c36524}
                  - {17'b0, last_day};

        yc100     = {1'b0, div_rsp.quotient[8:0] >= 9'd100}
                  + {1'b0, div_rsp.quotient[8:0] >= 9'd200}
                  + {1'b0, div_rsp.quotient[8:0] >= 9'd300};
        yoe_base  = {9'b0, div_rsp.quotient[8:0]} * DAYS_PER_YEAR
                  + {11'b0, div_rsp.quotient[8:2]} - {16'b0, yc100};
        doy_full  = doe_reg - yoe_base;
        mp_num    = {3'b0, doy_reg} * 12'd5 + 12'd2;

        mp_val    = div_rsp.quotient[3:0];
        day_full  = doy_reg - month_offset(mp_val) + 9'd1;
        month_val = (mp_val < 4'd10) ? (mp_val + 4'd3) : (mp_val - 4'd9);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_WIDEN;
            end
            ST_WIDEN:
                state_next = ST_DAYS;
            ST_DAYS:
            begin
                if (div_rsp.done)
                    state_next = days_oor ? ST_OUT : ST_ERA;
            end
            ST_ERA:
            begin
                if (div_rsp.done)
                    state_next = ST_CENT;
            end
            ST_CENT:
            begin
                if (div_rsp.done)
                    state_next = ST_YOE;
            end
            ST_YOE:
            begin
                if (div_rsp.done)
                    state_next = ST_DOY;
            end
            ST_DOY:
                state_next = ST_MONTH;
            ST_MONTH:
            begin
                if (div_rsp.done)
                    state_next = ST_HOUR;
            end
            ST_HOUR:
            begin
                if (div_rsp.done)
                    state_next = ST_MIN;
            end
            ST_MIN:
            begin
                if (div_rsp.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // divider launches and register updates
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = SECS_PER_DAY;
        div_req.steps    = STEPS_DAYS;

        func_next    = func_reg;
        secs_next    = secs_reg;
        start_next   = start_reg;
        sec_day_next = sec_day_reg;
        era_next     = era_reg;
        doe_next     = doe_reg;
        yoe_next     = yoe_reg;
        doy_next     = doy_reg;
        year_next    = year_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        oor_next     = oor_reg;

        case (state_reg)
            ST_IDLE:
            begin
                func_next  = func;
                secs_next  = seconds_in;
                start_next = {1'b0, now_seconds} - SERIAL_HALF;
            end
            ST_WIDEN:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = day_dividend;
                div_req.divisor  = SECS_PER_DAY;
                div_req.steps    = STEPS_DAYS;
            end
            ST_DAYS:
            begin
                if (div_rsp.done)
                begin
                    sec_day_next = div_rsp.remainder[16:0];
                    oor_next     = days_oor;
                    if (days_oor)
                    begin
                        year_next   = '0;
                        month_next  = '0;
                        day_next    = '0;
                        hour_next   = '0;
                        minute_next = '0;
                        second_next = '0;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {z_val, 42'b0};
                        div_req.divisor  = DAYS_PER_ERA;
                        div_req.steps    = STEPS_ERA;
                    end
                end
            end
            ST_ERA:
            begin
                if (div_rsp.done)
                begin
                    era_next         = div_rsp.quotient[4:0];
                    doe_next         = div_rsp.remainder;
                    div_req.start    = 1'b1;
                    div_req.dividend = {div_rsp.remainder, 46'b0};
                    div_req.divisor  = DAYS_PER_4Y;
                    div_req.steps    = STEPS_18B;
                end
            end
            ST_CENT:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {yoe_num, 46'b0};
                    div_req.divisor  = DAYS_PER_YEAR;
                    div_req.steps    = STEPS_18B;
                end
            end
            ST_YOE:
            begin
                if (div_rsp.done)
                begin
                    yoe_next = div_rsp.quotient[8:0];
                    doy_next = doy_full[8:0];
                end
            end
            ST_DOY:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {mp_num, 52'b0};
                div_req.divisor  = MONTH_DIV;
                div_req.steps    = STEPS_12B;
            end
            ST_MONTH:
            begin
                if (div_rsp.done)
                begin
                    day_next         = day_full[4:0];
                    month_next       = month_val;
                    year_next        = {9'b0, era_reg} * YEARS_PER_ERA + {5'b0, yoe_reg}
                                     + {13'b0, month_val <= 4'd2};
                    div_req.start    = 1'b1;
                    div_req.dividend = {1'b0, sec_day_reg, 46'b0};
                    div_req.divisor  = SECS_PER_HOUR;
                    div_req.steps    = STEPS_18B;
                end
            end
            ST_HOUR:
            begin
                if (div_rsp.done)
                begin
                    hour_next        = div_rsp.quotient[4:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = {div_rsp.remainder[11:0], 52'b0};
                    div_req.divisor  = SECS_PER_MIN;
                    div_req.steps    = STEPS_12B;
                end
            end
            ST_MIN:
            begin
                if (div_rsp.done)
                begin
                    minute_next = div_rsp.quotient[5:0];
                    second_next = div_rsp.remainder[5:0];
                end
            end
            ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        secs_reg    <= secs_next;
        start_reg   <= start_next;
        sec_day_reg <= sec_day_next;
        era_reg     <= era_next;
        doe_reg     <= doe_next;
        yoe_reg     <= yoe_next;
        doy_reg     <= doy_next;
        year_reg    <= year_next;
        month_reg   <= month_next;
        day_reg     <= day_next;
        hour_reg    <= hour_next;
        minute_reg  <= minute_next;
        second_reg  <= second_next;
        oor_reg     <= oor_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = (state_reg == ST_OUT);
    assign year         = year_reg;
    assign month        = month_reg;
    assign day          = day_reg;
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

FILE: rtl/esc_check.sv
// esc_check: port-level checks on the epoch seconds to calendar block, bound to the top
// depends on epoch_seconds_to_calendar_top
`default_nettype none

module esc_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [13:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second,
    input logic        out_of_range
);

    // a stalled result keeps its year, month, day, second and out_of_range fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(year) && $stable(month)
            && $stable(day) && $stable(second) && $stable(out_of_range))
        else $error("stalled result changed");

    // an accepted request closes the input, with no result shown yet
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !out_valid)
        else $error("input open right after a request");

    // one request in flight: no new request while a result is shown
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result waits");

    // out of range results carry zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> year == 14'd0 && month == 4'd0 && day == 5'd0
            && hour == 5'd0 && minute == 6'd0 && second == 6'd0)
        else $error("out of range result has non-zero fields");

    // in range results stay within calendar limits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_of_range |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1
            && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59
            && year >= 14'd1970 && year <= 14'd9999)
        else $error("calendar field out of limits");

endmodule

bind epoch_seconds_to_calendar_top esc_check u_esc_check (.*);

`default_nettype wire
